// ===== hw/rtl/hqp_pkg.sv =====
package hqp_pkg;

    localparam int unsigned OP_W   = 2;
    localparam int unsigned KEY_W  = 31;
    localparam int unsigned REC_W  = 31;
    localparam int unsigned SLOT_W = 4;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_REMOVE = 2'd2
    } op_e;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2
    } status_e;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [KEY_W-1:0] key;
        logic [REC_W-1:0] record_id;
    } request_t;

    typedef struct packed {
        status_e           status;
        logic [SLOT_W-1:0] slot;
    } response_t;

    // one table slot as held in the memory
    typedef struct packed {
        logic             valid;
        logic [REC_W-1:0] record;
    } entry_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_REDUCE,
        S_PROBE
    } state_e;

    typedef struct packed {
        logic    clear_wr;
        logic    load;
        logic    reduce;
        logic    seed;
        logic    issue;
        logic    commit;
        logic    respond;
        status_e resp_status;
    } ctrl_cmd_t;

    typedef struct packed {
        logic            clear_last;
        logic            reduce_done;
        logic            issue_left;
        logic            inflight;
        logic            hit;
        logic [OP_W-1:0] op;
    } ctrl_stat_t;

endpackage

// ===== hw/rtl/hqp_ctrl.sv =====
module hqp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [1:0]            operation,
    input  hqp_pkg::ctrl_stat_t   stat,
    output logic                  busy,
    output hqp_pkg::ctrl_cmd_t    cmd
);

    hqp_pkg::state_e state_reg;
    hqp_pkg::state_e state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hqp_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.resp_status = hqp_pkg::ST_MISSING;
        unique case (state_reg)
            hqp_pkg::S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = hqp_pkg::S_IDLE;
                end
            end
            hqp_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (operation == hqp_pkg::OP_INSERT ||
                        operation == hqp_pkg::OP_SEARCH ||
                        operation == hqp_pkg::OP_REMOVE)
                    begin
                        state_next = hqp_pkg::S_REDUCE;
                    end
                    else
                    begin
                        // unused code: answer at once
                        cmd.respond     = 1'b1;
                        cmd.resp_status = hqp_pkg::ST_MISSING;
                    end
                end
            end
            hqp_pkg::S_REDUCE:
            begin
                if (stat.reduce_done)
                begin
                    cmd.seed   = 1'b1;
                    state_next = hqp_pkg::S_PROBE;
                end
                else
                begin
                    cmd.reduce = 1'b1;
                end
            end
            hqp_pkg::S_PROBE:
            begin
                cmd.issue = stat.issue_left;
                priority if (stat.inflight && stat.hit)
                begin
                    cmd.commit      = (stat.op != hqp_pkg::OP_SEARCH);
                    cmd.respond     = 1'b1;
                    cmd.resp_status = hqp_pkg::ST_OK;
                    state_next      = hqp_pkg::S_IDLE;
                end
                else if (!stat.inflight && !stat.issue_left)
                begin
                    cmd.respond     = 1'b1;
                    cmd.resp_status = (stat.op == hqp_pkg::OP_INSERT) ?
                                      hqp_pkg::ST_FULL : hqp_pkg::ST_MISSING;
                    state_next      = hqp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = hqp_pkg::S_CLEAR;
            end
        endcase
    end

    assign busy = (state_reg != hqp_pkg::S_IDLE);

endmodule

// ===== hw/rtl/hqp_datapath.sv =====
module hqp_datapath #(
    parameter int unsigned TABLE_SIZE = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  hqp_pkg::request_t     request,
    input  hqp_pkg::ctrl_cmd_t    cmd,
    output hqp_pkg::ctrl_stat_t   stat,
    output logic                  done,
    output hqp_pkg::response_t    response
);

    localparam int unsigned KEY_W  = hqp_pkg::KEY_W;
    localparam int unsigned SLOT_W = hqp_pkg::SLOT_W;
    localparam int unsigned IDX_W  = $clog2(TABLE_SIZE);
    localparam int unsigned SUM_W  = IDX_W + 1;
    localparam int unsigned CNT_W  = $clog2(TABLE_SIZE + 1);
    localparam int unsigned RED_W  = 2;
    localparam int unsigned PROD_W = 2 * KEY_W + 1;
    localparam int unsigned RCP_SH = KEY_W + IDX_W;
    localparam bit          IS_POW2 = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);

    localparam logic [SUM_W-1:0] N_SUM    = SUM_W'(TABLE_SIZE);
    localparam logic [IDX_W-1:0] N_IDX    = IDX_W'(TABLE_SIZE);
    localparam logic [IDX_W-1:0] STEP0    = IDX_W'(7 % TABLE_SIZE);
    localparam logic [SUM_W-1:0] STEP_INC = SUM_W'(10 % TABLE_SIZE);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_SIZE);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_SIZE - 1);
    localparam logic [RED_W-1:0] RED_STEPS = 2'd2;

    // ceil(2^RCP_SH / N): exact quotient for every 31-bit key
    localparam longint unsigned RCP_L =
        ((64'd1 << RCP_SH) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
    localparam logic [KEY_W:0] RCP_M = (KEY_W + 1)'(RCP_L);

    hqp_pkg::entry_t mem [TABLE_SIZE];

    logic [1:0]          op_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [KEY_W-1:0]    rec_reg;
    logic [IDX_W-1:0]    quot_reg;
    logic [IDX_W-1:0]    rem_reg;
    logic [RED_W-1:0]    red_cnt_reg;
    logic [IDX_W-1:0]    pos_reg;
    logic [IDX_W-1:0]    step_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [IDX_W-1:0]    addr_reg;
    logic                inflight_reg;
    hqp_pkg::entry_t     rd_reg;
    hqp_pkg::response_t  resp_reg;
    logic                done_reg;

    logic [PROD_W-1:0]   rcp_prod;
    logic [2*IDX_W-1:0]  quot_mul;
    logic [IDX_W-1:0]    rem_calc;
    logic [SUM_W-1:0]    pos_sum;
    logic [SUM_W-1:0]    pos_mod;
    logic [SUM_W-1:0]    step_sum;
    logic [SUM_W-1:0]    step_mod;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    hqp_pkg::entry_t     wr_data;
    logic                is_insert;

    // key mod N: quotient low bits by reciprocal multiply, then key - q*N
    assign rcp_prod = PROD_W'(key_reg) * PROD_W'(RCP_M);
    assign quot_mul = {{IDX_W{1'b0}}, quot_reg} * {{IDX_W{1'b0}}, N_IDX};
    assign rem_calc = key_reg[IDX_W-1:0] - quot_mul[IDX_W-1:0];

    // next probe: pos += step, step += 10, both mod N
    assign pos_sum  = {1'b0, pos_reg} + {1'b0, step_reg};
    assign pos_mod  = (pos_sum >= N_SUM) ? (pos_sum - N_SUM) : pos_sum;
    assign step_sum = {1'b0, step_reg} + STEP_INC;
    assign step_mod = (step_sum >= N_SUM) ? (step_sum - N_SUM) : step_sum;

    assign is_insert = (op_reg == hqp_pkg::OP_INSERT);

    assign wr_en   = cmd.clear_wr | cmd.commit;
    assign wr_addr = cmd.clear_wr ? cnt_reg[IDX_W-1:0] : addr_reg;
    always_comb
    begin
        wr_data = '0;
        if (cmd.commit && is_insert)
        begin
            wr_data.valid  = 1'b1;
            wr_data.record = rec_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.issue)
        begin
            rd_reg <= mem[pos_reg];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            red_cnt_reg  <= '0;
            inflight_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            inflight_reg <= cmd.issue;
            done_reg     <= cmd.respond;
            if (cmd.seed)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.clear_wr || cmd.issue)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.load)
            begin
                red_cnt_reg <= IS_POW2 ? '0 : RED_STEPS;
            end
            else if (cmd.reduce)
            begin
                red_cnt_reg <= red_cnt_reg - 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= request.operation;
            key_reg   <= request.key;
            rec_reg   <= request.record_id;
            rem_reg   <= IS_POW2 ? request.key[IDX_W-1:0] : '0;
        end
        else if (cmd.reduce)
        begin
            // first step latches the quotient, second the remainder
            quot_reg  <= rcp_prod[RCP_SH +: IDX_W];
            rem_reg   <= rem_calc;
        end
        if (cmd.seed)
        begin
            pos_reg  <= rem_reg;
            step_reg <= STEP0;
        end
        else if (cmd.issue)
        begin
            addr_reg <= pos_reg;
            pos_reg  <= pos_mod[IDX_W-1:0];
            step_reg <= step_mod[IDX_W-1:0];
        end
        if (cmd.respond)
        begin
            resp_reg.status <= cmd.resp_status;
            resp_reg.slot   <= (cmd.resp_status == hqp_pkg::ST_OK) ?
                               SLOT_W'(addr_reg) : '0;
        end
    end

    always_comb
    begin
        stat             = '0;
        stat.clear_last  = (cnt_reg == CNT_LAST);
        stat.reduce_done = (red_cnt_reg == '0);
        stat.issue_left  = (cnt_reg != CNT_FULL);
        stat.inflight    = inflight_reg;
        stat.op          = op_reg;
        stat.hit         = is_insert ? !rd_reg.valid :
                           (rd_reg.valid && (rd_reg.record == key_reg));
    end

    assign done     = done_reg;
    assign response = resp_reg;

endmodule

// ===== hw/rtl/hash_table_quadratic_probe_core.sv =====
// Sequence: start loads the request, then key mod N is formed (pow2 TABLE_SIZE: low key
// bits at load; other: reciprocal multiply, then key - q*N), then the probe loop runs.
// Throughput: one transaction at a time, next start accepted in the cycle done is high;
// probe loop reads one table slot per cycle from the single read port.
// Unused operation code answers in the cycle after start. Receiver cannot stall: done is a
// one-cycle strobe. Reset: clearing pass over every slot with busy high, table left empty.
module hash_table_quadratic_probe_core #(
    parameter int unsigned TABLE_SIZE = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  hqp_pkg::request_t   request,
    output logic                busy,
    output logic                done,
    output hqp_pkg::response_t  response
);

    // Structure:
    //   hqp_ctrl     - state machine: clearing pass, idle, key reduction, probe loop.
    //   hqp_datapath - slot memory ({valid, record}), probe address generator and
    //                  response register.
    //
    // Probe address: p(i) = (key + 2i + 5i^2) mod N, stepped incrementally:
    //   p(i+1) = p(i) + d(i), d(0) = 7, d(i+1) = d(i) + 10, all kept mod N,
    //   so each step is one add and a conditional subtract.
    //
    // Probe loop is pipelined by one: the read for probe i+1 is issued while the
    // registered data of probe i is checked. A hit drops the read in flight.
    // Insert wants the first empty slot; search/remove want a valid slot whose
    // record id equals the key and walk all N probes before missing.
    // The stored key is never read back, so only valid and record id are kept.

    hqp_pkg::ctrl_cmd_t  cmd;
    hqp_pkg::ctrl_stat_t stat;

    hqp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (request.operation),
        .stat      (stat),
        .busy      (busy),
        .cmd       (cmd)
    );

    hqp_datapath #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .cmd      (cmd),
        .stat     (stat),
        .done     (done),
        .response (response)
    );

    // A valid operation accepted in idle moves the block into work.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (request.operation == hqp_pkg::OP_INSERT ||
                            request.operation == hqp_pkg::OP_SEARCH ||
                            request.operation == hqp_pkg::OP_REMOVE)) |=> busy)
        else $error("valid transaction accepted but block not busy");

    // Outside the clearing pass, memory is only modified on a checked hit.
    a_commit_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (stat.inflight && stat.hit))
        else $error("table write without a checked hit");

    // Failed transactions report slot zero.
    a_fail_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (done && response.status != hqp_pkg::ST_OK) |-> (response.slot == '0))
        else $error("nonzero slot on failed transaction");

endmodule
